>>> sv/art_pkg.sv
// Shared types and constants for the address range table.
package art_pkg;

  localparam int ADDR_W      = 32;
  localparam int ENTRIES_DEF = 8;

  typedef enum logic [1:0] {
    OP_PURGE_ALL     = 2'd0,
    OP_PURGE_ONE     = 2'd1,
    OP_PURGE_INSTALL = 2'd2,
    OP_INSTALL       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_SHIFT,
    S_SHIFT_WR
  } eng_state_t;

  // Classified request as it travels from the front to the engine
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic              pair_zero;
  } cmd_t;

endpackage

>>> sv/art_front.sv
// Front stage: accept request items, classify them and hold them for the queue.
module art_front import art_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        operation,
  input  logic [ADDR_W-1:0] start_address,
  input  logic [ADDR_W-1:0] end_address,
  output cmd_t              cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);

  logic hold_valid;
  logic take;

  assign full      = hold_valid && !cmd_ready;
  assign take      = push && !full;
  assign cmd_valid = hold_valid;

  // Track the holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  // Classify the item on the way in
  always_ff @(posedge clk) begin
    if (take) begin
      cmd.op         <= op_t'(operation);
      cmd.start_addr <= start_address;
      cmd.end_addr   <= end_address;
      cmd.pair_zero  <= (start_address == '0) && (end_address == '0);
    end
  end

endmodule

>>> sv/art_queue.sv
// Two-entry queue of classified requests between front and engine.
module art_queue import art_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t in_cmd,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t out_cmd,
  output logic out_valid,
  input  logic out_take
);

  cmd_t       slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       wr_en;
  logic       rd_en;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_take && out_valid;
  assign out_cmd   = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 2'd1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

>>> sv/art_engine.sv
// Engine: packed range table in a memory, slot walk, shift on removal, result item.
module art_engine import art_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int CNT_W  = $clog2(ENTRIES + 1),
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             cmd_valid,
  output logic             cmd_take,
  output logic             res_valid,
  output status_t          res_status,
  input  logic             res_take,
  output logic [CNT_W-1:0] fill_count
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

  // Table memory: entries at or above the fill count are don't-care
  logic [2*ADDR_W-1:0] mem [0:ENTRIES-1];
  logic [2*ADDR_W-1:0] rdata;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic [2*ADDR_W-1:0] wdata;
  logic                we;

  eng_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] idx_inc;
  cmd_t             cur, cur_next;
  logic             res_set;
  status_t          res_code;
  logic             match;

  assign fill_count = count;
  assign idx_inc    = idx + CNT_W'(1);
  assign match      = (rdata == {cur.start_addr, cur.end_addr});

  // Memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Hold state, count, walk index and the current request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // Hold the result item until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_set) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      res_status <= res_code;
    end
  end

  // Sequence the walk over the slots
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    cur_next   = cur;
    cmd_take   = 1'b0;
    res_set    = 1'b0;
    res_code   = ST_OK;
    we         = 1'b0;
    waddr      = idx[IDX_W-1:0];
    wdata      = {cur.start_addr, cur.end_addr};
    raddr      = idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (cmd_valid && !res_valid) begin
          cmd_take = 1'b1;
          cur_next = cmd;
          idx_next = '0;
          case (cmd.op)
            OP_PURGE_ALL: begin
              count_next = '0;
              res_set    = 1'b1;
            end
            OP_PURGE_INSTALL: begin
              // Cleared table: slot zero takes the pair unless it is empty
              we         = !cmd.pair_zero;
              waddr      = '0;
              wdata      = {cmd.start_addr, cmd.end_addr};
              count_next = cmd.pair_zero ? '0 : CNT_W'(1);
              res_set    = 1'b1;
            end
            default: begin
              state_next = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx == count) begin
          // Past the occupied slots: the first empty slot, if any, is here
          res_set    = 1'b1;
          state_next = S_IDLE;
          if (cur.op == OP_INSTALL) begin
            if (count == CNT_MAX) begin
              res_code = ST_FULL;
            end else if (!cur.pair_zero) begin
              we         = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end else if ((count == CNT_MAX) || !cur.pair_zero) begin
            res_code = ST_NOT_FOUND;
          end
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (match) begin
          if (cur.op == OP_INSTALL) begin
            res_set    = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_SHIFT;
          end
        end else begin
          idx_next   = idx_inc;
          state_next = S_SCAN;
        end
      end
      S_SHIFT: begin
        raddr = idx_inc[IDX_W-1:0];
        if (idx_inc == count) begin
          count_next = count - CNT_W'(1);
          res_set    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        // Move the later slot down by one
        we         = 1'b1;
        wdata      = rdata;
        idx_next   = idx_inc;
        state_next = S_SHIFT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/address_range_table.sv
// Purge all and purge-and-install complete as the engine takes the item; install and purge one
// walk the occupied slots (scan, compare), install stops where it finds its pair, and purge one
// then shifts the later slots down. The engine takes the next queued item the cycle after the
// result is popped, so it works on one item at a time;
// front and queue hold up to three more items meanwhile.
// Reset: synchronous; empties front, queue and result, sets the fill count to zero.
module address_range_table import art_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        operation,
  input  logic [ADDR_W-1:0] start_address,
  input  logic [ADDR_W-1:0] end_address,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

  cmd_t             front_cmd;
  cmd_t             q_cmd;
  logic             front_valid;
  logic             front_ready;
  logic             q_valid;
  logic             q_take;
  logic             res_valid;
  status_t          res_status;
  logic [CNT_W-1:0] fill_count;

  art_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .operation     (operation),
    .start_address (start_address),
    .end_address   (end_address),
    .cmd           (front_cmd),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready)
  );

  art_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_cmd    (front_cmd),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_cmd   (q_cmd),
    .out_valid (q_valid),
    .out_take  (q_take)
  );

  art_engine #(
    .ENTRIES (ENTRIES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd        (q_cmd),
    .cmd_valid  (q_valid),
    .cmd_take   (q_take),
    .res_valid  (res_valid),
    .res_status (res_status),
    .res_take   (pop && res_valid),
    .fill_count (fill_count)
  );

  assign empty  = !res_valid;
  assign status = res_status;

  // Fill count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_MAX)
    else $error("fill count beyond table size");

  // A table-full result implies every slot is occupied
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_FULL) |-> fill_count == CNT_MAX)
    else $error("table full reported with free slots");

  // Reset empties the table and the result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (fill_count == '0 && empty))
    else $error("reset did not clear table or result");

endmodule
